// File: src/cv3_pkg.sv
// Shared constants and controller/datapath command and status types for the 3x3 convolution.
package cv3_pkg;

  localparam int CV3_COEFF_BITS = 7;   // default coefficient width
  localparam int CV3_CFG_W      = 63;  // kernel register width
  localparam int CV3_PIX_W      = 8;
  localparam int CV3_TAPS       = 9;
  localparam int CV3_MAC_ROWS   = 3;   // one kernel row per MAC cycle
  localparam int CV3_DIV_STEPS  = 8;   // one quotient bit per cycle
  localparam logic [CV3_PIX_W-1:0] CV3_PIX_MAX = 8'd255;

  typedef struct packed {
    logic       accept;     // input item taken this cycle
    logic       mac_en;     // accumulate one kernel row
    logic [1:0] mac_row;    // kernel row being accumulated
    logic       check;      // sign, magnitude and saturation check
    logic       div_step;   // one restoring divide step
    logic       emit;       // load the output register
    logic       last_job;   // result belongs to the rightmost column
    logic       shift_win;  // move the window one column right
  } cv3_cmd_t;

  typedef struct packed {
    logic need_result;  // incoming item yields at least one result
    logic first_col;    // incoming item is the first column of its row
    logic row_end;      // item being worked on ends its row
    logic out_free;     // output register can take a result
  } cv3_sts_t;

endpackage

// File: src/cv3_pix_if.sv
// Input channel: one pixel column item with row and frame markers.
interface cv3_pix_if;
  import cv3_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CV3_PIX_W-1:0] top_pixel;
  logic [CV3_PIX_W-1:0] middle_pixel;
  logic [CV3_PIX_W-1:0] bottom_pixel;
  logic                 last_in_row;
  logic                 last_in_frame;

  modport source (
    output valid, top_pixel, middle_pixel, bottom_pixel, last_in_row, last_in_frame,
    input  ready
  );

  modport sink (
    input  valid, top_pixel, middle_pixel, bottom_pixel, last_in_row, last_in_frame,
    output ready
  );
endinterface

// File: src/cv3_res_if.sv
// Result channel: one filtered pixel item with row and frame markers.
interface cv3_res_if;
  import cv3_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [CV3_PIX_W-1:0] result_pixel;
  logic                 end_of_row;
  logic                 end_of_frame;

  modport source (
    output valid, result_pixel, end_of_row, end_of_frame,
    input  ready
  );

  modport sink (
    input  valid, result_pixel, end_of_row, end_of_frame,
    output ready
  );
endinterface

// File: src/cv3_ctrl.sv
// Controller: sequences accept, row-wise MAC, divide and emit for each result.
module cv3_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  cv3_pkg::cv3_sts_t sts,
  output cv3_pkg::cv3_cmd_t cmd
);
  import cv3_pkg::*;

  localparam int BIT_W = $clog2(CV3_DIV_STEPS);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MAC,
    S_CHECK,
    S_DIV,
    S_EMIT
  } state_t;

  state_t           state_r, state_nxt;
  logic [1:0]       row_r, row_nxt;
  logic [BIT_W-1:0] bit_r, bit_nxt;
  logic             second_r, second_nxt;
  logic             accept;

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_nxt  = state_r;
    row_nxt    = row_r;
    bit_nxt    = bit_r;
    second_nxt = second_r;
    cmd        = '0;
    cmd.mac_row  = row_r;
    cmd.last_job = second_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.accept = 1'b1;
          row_nxt    = '0;
          // a first column that also ends its row goes straight to its own right-padded result
          second_nxt = sts.first_col;
          if (sts.need_result) begin
            state_nxt = S_MAC;
          end
        end
      end
      S_MAC: begin
        cmd.mac_en = 1'b1;
        if (row_r == 2'(CV3_MAC_ROWS - 1)) begin
          state_nxt = S_CHECK;
        end else begin
          row_nxt = row_r + 2'd1;
        end
      end
      S_CHECK: begin
        cmd.check = 1'b1;
        bit_nxt   = BIT_W'(CV3_DIV_STEPS - 1);
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (bit_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          bit_nxt = bit_r - BIT_W'(1);
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit = 1'b1;
          if (!second_r && sts.row_end) begin
            cmd.shift_win = 1'b1;
            second_nxt    = 1'b1;
            row_nxt       = '0;
            state_nxt     = S_MAC;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      row_r    <= '0;
      bit_r    <= '0;
      second_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      row_r    <= row_nxt;
      bit_r    <= bit_nxt;
      second_r <= second_nxt;
    end
  end

endmodule

// File: src/cv3_datapath.sv
// Datapath: column history, window, row MAC, sign/saturation check, divider, output register.
module cv3_datapath #(
  parameter int COEFF_BITS = cv3_pkg::CV3_COEFF_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cv3_pkg::CV3_CFG_W-1:0] cfg_wdata,
  input  logic [cv3_pkg::CV3_PIX_W-1:0] in_top,
  input  logic [cv3_pkg::CV3_PIX_W-1:0] in_mid,
  input  logic [cv3_pkg::CV3_PIX_W-1:0] in_bot,
  input  logic                          in_last_row,
  input  logic                          in_last_frame,
  input  cv3_pkg::cv3_cmd_t             cmd,
  output cv3_pkg::cv3_sts_t             sts,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [cv3_pkg::CV3_PIX_W-1:0] out_pixel,
  output logic                          out_eor,
  output logic                          out_eof
);
  import cv3_pkg::*;

  localparam int COL_W   = 3 * CV3_PIX_W;
  localparam int KS_W    = COEFF_BITS + 4;             // kernel sum, signed
  localparam int PROD_W  = COEFF_BITS + CV3_PIX_W + 1; // coeff times zero-extended pixel
  localparam int ACC_W   = PROD_W + 4;                 // nine products, signed
  localparam int DSH_W   = KS_W + CV3_DIV_STEPS;
  localparam int KBITS   = CV3_TAPS * COEFF_BITS;

  // kernel register and its derived divisor
  logic [KBITS-1:0]        coeff_r;
  logic [KS_W-1:0]         ks_mag_r;
  logic                    ks_neg_r;
  logic signed [KS_W-1:0]  ks_sum;
  logic [KS_W-1:0]         ks_mag_nxt;

  // column history and working window
  logic [COL_W-1:0]        older_r, newer_r;
  logic                    seen_r;
  logic [COL_W-1:0]        win_l_r, win_c_r, win_r_r;
  logic                    row_end_r, frame_r;
  logic [COL_W-1:0]        in_col;
  logic                    row_end_in;

  // MAC
  logic signed [COEFF_BITS-1:0] cf [3];
  logic signed [CV3_PIX_W:0]    px [3];
  logic signed [PROD_W-1:0]     prod [3];
  logic signed [ACC_W-1:0]      row_sum;
  logic signed [ACC_W-1:0]      acc_r;

  // divide
  logic                    acc_neg;
  logic [ACC_W-1:0]        acc_mag;
  logic [ACC_W-1:0]        rem_r;
  logic [CV3_PIX_W-1:0]    q_r;
  logic [DSH_W-1:0]        dsh_r;
  logic                    zero_r, sat_r;
  logic                    div_ge;

  // output register
  logic                    out_valid_r;
  logic [CV3_PIX_W-1:0]    out_pixel_r;
  logic                    out_eor_r, out_eof_r;

  assign in_col     = {in_bot, in_mid, in_top};
  assign row_end_in = in_last_row | in_last_frame;

  always_comb begin
    logic signed [COEFF_BITS-1:0] c;
    c      = '0;
    ks_sum = '0;
    for (int k = 0; k < CV3_TAPS; k++) begin
      c      = cfg_wdata[k*COEFF_BITS +: COEFF_BITS];
      ks_sum = ks_sum + KS_W'(c);
    end
    if (ks_sum == '0) begin
      ks_mag_nxt = KS_W'(1);
    end else if (ks_sum[KS_W-1]) begin
      ks_mag_nxt = KS_W'(-ks_sum);
    end else begin
      ks_mag_nxt = KS_W'(ks_sum);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      coeff_r  <= '0;
      ks_mag_r <= KS_W'(1);
      ks_neg_r <= 1'b0;
    end else if (cfg_we) begin
      coeff_r  <= cfg_wdata[KBITS-1:0];
      ks_mag_r <= ks_mag_nxt;
      ks_neg_r <= ks_sum[KS_W-1];
    end
  end

  // one kernel row: left, centre and right taps
  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cf[j] = '0;
      px[j] = '0;
    end
    for (int r = 0; r < CV3_MAC_ROWS; r++) begin
      if (cmd.mac_row == 2'(r)) begin
        cf[0] = coeff_r[(3*r)*COEFF_BITS +: COEFF_BITS];
        cf[1] = coeff_r[(3*r+1)*COEFF_BITS +: COEFF_BITS];
        cf[2] = coeff_r[(3*r+2)*COEFF_BITS +: COEFF_BITS];
        px[0] = {1'b0, win_l_r[CV3_PIX_W*r +: CV3_PIX_W]};
        px[1] = {1'b0, win_c_r[CV3_PIX_W*r +: CV3_PIX_W]};
        px[2] = {1'b0, win_r_r[CV3_PIX_W*r +: CV3_PIX_W]};
      end
    end
    for (int j = 0; j < 3; j++) begin
      prod[j] = cf[j] * px[j];
    end
    row_sum = ACC_W'(prod[0]) + ACC_W'(prod[1]) + ACC_W'(prod[2]);
  end

  assign acc_neg = acc_r[ACC_W-1];
  assign acc_mag = acc_neg ? ACC_W'(-acc_r) : ACC_W'(acc_r);
  assign div_ge  = (rem_r >= ACC_W'(dsh_r));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      older_r     <= '0;
      newer_r     <= '0;
      seen_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.accept) begin
        if (row_end_in) begin
          older_r <= '0;
          newer_r <= '0;
          seen_r  <= 1'b0;
        end else begin
          older_r <= seen_r ? newer_r : '0;
          newer_r <= in_col;
          seen_r  <= 1'b1;
        end
      end
      if (cmd.emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      // a first column sits in the centre with zero padding on both sides
      win_l_r   <= seen_r ? older_r : '0;
      win_c_r   <= seen_r ? newer_r : in_col;
      win_r_r   <= seen_r ? in_col : '0;
      row_end_r <= row_end_in;
      frame_r   <= in_last_frame;
    end else if (cmd.shift_win) begin
      win_l_r <= win_c_r;
      win_c_r <= win_r_r;
      win_r_r <= '0;
    end
    if (cmd.mac_en) begin
      acc_r <= (cmd.mac_row == 2'd0) ? row_sum : acc_r + row_sum;
    end
    if (cmd.check) begin
      // opposite signs or a zero sum truncate to zero, then clamp to zero
      zero_r <= (acc_r == '0) || (acc_neg != ks_neg_r);
      sat_r  <= acc_mag >= ACC_W'({ks_mag_r, CV3_DIV_STEPS'(0)});
      rem_r  <= acc_mag;
      q_r    <= '0;
      dsh_r  <= {1'b0, ks_mag_r, (CV3_DIV_STEPS-1)'(0)};
    end else if (cmd.div_step) begin
      if (div_ge) begin
        rem_r <= rem_r - ACC_W'(dsh_r);
      end
      q_r   <= {q_r[CV3_PIX_W-2:0], div_ge};
      dsh_r <= dsh_r >> 1;
    end
    if (cmd.emit) begin
      out_pixel_r <= zero_r ? '0 : (sat_r ? CV3_PIX_MAX : q_r);
      out_eor_r   <= cmd.last_job;
      out_eof_r   <= cmd.last_job & frame_r;
    end
  end

  assign sts.need_result = seen_r | row_end_in;
  assign sts.first_col   = !seen_r;
  assign sts.row_end     = row_end_r;
  assign sts.out_free    = !out_valid_r || out_ready;

  assign out_valid = out_valid_r;
  assign out_pixel = out_pixel_r;
  assign out_eor   = out_eor_r;
  assign out_eof   = out_eof_r;

endmodule

// File: src/conv3x3_zero_pad_normalized.sv
// 3x3 convolution with zero padding and kernel-sum normalization over a pixel column stream.
//
// in_ch carries one image column (top, middle, bottom pixel) per item, plus
// last_in_row / last_in_frame markers; the source supplies zero rows above and
// below the image. out_ch carries one saturated 0..255 result per item.
// cfg_we / cfg_wdata write the packed kernel; write it only while idle.
// An item yields the result of the previous column, and a row-ending item also
// yields its own right-padded result, so zero, one or two results per item.
// Each result passes from the accepting edge through the row-wise MAC, the sign
// and saturation check and a one-bit-per-cycle restoring divider, then the
// load into the output register.
// The next item is taken as soon as the last result sits in the output
// register, even if the receiver has not taken it yet; when the receiver
// stalls, a new result waits in the divider until the register frees.
// Reset (synchronous, active low) clears the column history, empties the
// output register and loads a zero kernel, whose sum counts as one.
module conv3x3_zero_pad_normalized #(
  parameter int COEFF_BITS = cv3_pkg::CV3_COEFF_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [cv3_pkg::CV3_CFG_W-1:0] cfg_wdata,
  cv3_pix_if.sink                       in_ch,
  cv3_res_if.source                     out_ch
);
  import cv3_pkg::*;

  cv3_cmd_t cmd;
  cv3_sts_t sts;

  cv3_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cv3_datapath #(
    .COEFF_BITS (COEFF_BITS)
  ) u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .in_top        (in_ch.top_pixel),
    .in_mid        (in_ch.middle_pixel),
    .in_bot        (in_ch.bottom_pixel),
    .in_last_row   (in_ch.last_in_row),
    .in_last_frame (in_ch.last_in_frame),
    .cmd           (cmd),
    .sts           (sts),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_pixel     (out_ch.result_pixel),
    .out_eor       (out_ch.end_of_row),
    .out_eof       (out_ch.end_of_frame)
  );

endmodule
